// ----- rtl/vdhd_pkg.sv -----
package vdhd_pkg;

  localparam int FLUX_W     = 16;
  localparam int DIFF_W     = FLUX_W + 1;
  localparam int MAG_W      = 16;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int LEN_W      = 17;
  localparam int THR_W      = 17;
  localparam int SQRT_STEPS = SUM_W / 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int Q_DEPTH    = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_REF_X     = 3'd0;
  localparam cfg_idx_t REG_REF_Y     = 3'd1;
  localparam cfg_idx_t REG_REF_Z     = 3'd2;
  localparam cfg_idx_t REG_OPEN_THR  = 3'd3;
  localparam cfg_idx_t REG_CLOSE_THR = 3'd4;

  typedef struct packed {
    logic signed [FLUX_W-1:0] x;
    logic signed [FLUX_W-1:0] y;
    logic signed [FLUX_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic [LEN_W-1:0] avg;
    logic             door_open;
    logic             closing;
  } res_t;

endpackage

// ----- rtl/vdhd_fifo.sv -----
module vdhd_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  import vdhd_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(Q_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(Q_DEPTH);

  logic [WIDTH-1:0] data_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = data_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      data_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
      end
      if (do_push && !do_pop) begin
        count_r <= CNT_W'(count_r + 1'b1);
      end else if (do_pop && !do_push) begin
        count_r <= CNT_W'(count_r - 1'b1);
      end
    end
  end

endmodule

// ----- rtl/vdhd_front.sv -----
module vdhd_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  vdhd_pkg::vec_t             flux,
  input  vdhd_pkg::vec_t             ref_vec,
  output logic                       q_push,
  output logic [vdhd_pkg::SUM_W-1:0] q_data,
  input  logic                       q_full
);
  import vdhd_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SQ, ST_PUSH} state_t;

  state_t                   state_r;
  logic [1:0]               step_r;
  logic signed [DIFF_W-1:0] dx_r;
  logic signed [DIFF_W-1:0] dy_r;
  logic signed [DIFF_W-1:0] dz_r;
  logic [SQ_W-1:0]          prod_r;
  logic [SUM_W-1:0]         sum_r;
  logic signed [DIFF_W-1:0] d_sel;
  logic signed [DIFF_W-1:0] d_neg;
  logic [MAG_W-1:0]         mag;
  logic [SQ_W-1:0]          prod_nxt;

  // one squarer shared over the three axes
  always_comb begin
    unique case (step_r)
      2'd0:    d_sel = dx_r;
      2'd1:    d_sel = dy_r;
      default: d_sel = dz_r;
    endcase
    d_neg    = -d_sel;
    mag      = d_sel[DIFF_W-1] ? d_neg[MAG_W-1:0] : d_sel[MAG_W-1:0];
    prod_nxt = SQ_W'(mag) * SQ_W'(mag);
  end

  assign in_full = (state_r != ST_IDLE);
  assign q_push  = (state_r == ST_PUSH) && !q_full;
  assign q_data  = sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_push) begin
            dx_r    <= {ref_vec.x[FLUX_W-1], ref_vec.x} - {flux.x[FLUX_W-1], flux.x};
            dy_r    <= {ref_vec.y[FLUX_W-1], ref_vec.y} - {flux.y[FLUX_W-1], flux.y};
            dz_r    <= {ref_vec.z[FLUX_W-1], ref_vec.z} - {flux.z[FLUX_W-1], flux.z};
            sum_r   <= '0;
            step_r  <= '0;
            state_r <= ST_SQ;
          end
        end
        ST_SQ: begin
          // product is registered, so it lands the step after its operand is selected
          prod_r <= prod_nxt;
          if (step_r != 2'd0) begin
            sum_r <= sum_r + SUM_W'(prod_r);
          end
          step_r <= step_r + 2'd1;
          if (step_r == 2'd3) begin
            state_r <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (!q_full) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/vdhd_back.sv -----
module vdhd_back #(
  parameter int WINDOW_LENGTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  output logic                       q_pop,
  input  logic [vdhd_pkg::SUM_W-1:0] q_data,
  input  logic [vdhd_pkg::THR_W-1:0] open_thr,
  input  logic [vdhd_pkg::THR_W-1:0] close_thr,
  output logic                       r_push,
  output vdhd_pkg::res_t             r_data,
  input  logic                       r_full
);
  import vdhd_pkg::*;

  localparam int SLOT_W = $clog2(WINDOW_LENGTH);
  localparam int CNT_W  = $clog2(WINDOW_LENGTH + 1);
  localparam int TOT_W  = LEN_W + SLOT_W;
  localparam int STEP_W = $clog2(TOT_W + 1);
  localparam int REM_W  = LEN_W + 3;
  localparam logic [STEP_W-1:0] LAST_SQRT = STEP_W'(SQRT_STEPS - 1);
  localparam logic [STEP_W-1:0] LAST_DIV  = STEP_W'(TOT_W - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(WINDOW_LENGTH);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_LENGTH - 1);

  typedef enum logic [2:0] {ST_IDLE, ST_SQRT, ST_ACC, ST_DIV, ST_EMIT} state_t;

  state_t             state_r;
  logic [STEP_W-1:0]  step_r;
  logic [SUM_W-1:0]   rad_r;
  logic [REM_W-1:0]   rem_r;
  logic [LEN_W-1:0]   root_r;
  logic [LEN_W-1:0]   old_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [CNT_W-1:0]   fill_r;
  logic [TOT_W-1:0]   total_r;
  logic [TOT_W-1:0]   dvd_r;
  logic [CNT_W-1:0]   drem_r;
  logic               open_r;

  logic [LEN_W-1:0]   win_mem [WINDOW_LENGTH];

  logic [REM_W-1:0]   rem_sh;
  logic [REM_W-1:0]   trial;
  logic               sq_ge;
  logic [LEN_W-1:0]   old_val;
  logic [TOT_W-1:0]   total_nxt;
  logic [CNT_W-1:0]   fill_nxt;
  logic [CNT_W:0]     drem_sh;
  logic [CNT_W:0]     drem_sub;
  logic               dv_ge;
  logic [CNT_W-1:0]   drem_nxt;
  logic [LEN_W-1:0]   avg;
  logic               open_nxt;
  logic               closing;

  // square root: one result bit per cycle, two radicand bits brought down
  always_comb begin
    rem_sh = {rem_r[REM_W-3:0], rad_r[SUM_W-1 -: 2]};
    trial  = {1'b0, root_r, 2'b01};
    sq_ge  = (rem_sh >= trial);
  end

  // slots not yet written since reset count as zero
  always_comb begin
    old_val   = (fill_r == FULL_CNT) ? old_r : '0;
    total_nxt = total_r - TOT_W'(old_val) + TOT_W'(root_r);
    fill_nxt  = (fill_r == FULL_CNT) ? fill_r : CNT_W'(fill_r + 1'b1);
  end

  // restoring divide by the fill count, quotient shifts into dvd_r
  always_comb begin
    drem_sh  = {drem_r, dvd_r[TOT_W-1]};
    drem_sub = drem_sh - {1'b0, fill_r};
    dv_ge    = (drem_sh >= {1'b0, fill_r});
    drem_nxt = dv_ge ? drem_sub[CNT_W-1:0] : drem_sh[CNT_W-1:0];
  end

  // only the comparison for the state held before the beat applies
  always_comb begin
    avg = dvd_r[LEN_W-1:0];
    if (!open_r) begin
      closing  = 1'b0;
      open_nxt = (avg > open_thr);
    end else begin
      closing  = (avg < close_thr);
      open_nxt = !closing;
    end
  end

  assign q_pop  = (state_r == ST_IDLE) && !q_empty;
  assign r_push = (state_r == ST_EMIT) && !r_full;
  assign r_data = '{avg: avg, door_open: open_nxt, closing: closing};

  always_ff @(posedge clk) begin
    if (state_r == ST_ACC) begin
      win_mem[slot_r] <= root_r;
    end
    old_r <= win_mem[slot_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      slot_r  <= '0;
      fill_r  <= '0;
      total_r <= '0;
      open_r  <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            rad_r   <= q_data;
            rem_r   <= '0;
            root_r  <= '0;
            step_r  <= '0;
            state_r <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          rem_r  <= sq_ge ? REM_W'(rem_sh - trial) : rem_sh;
          root_r <= {root_r[LEN_W-2:0], sq_ge};
          rad_r  <= {rad_r[SUM_W-3:0], 2'b00};
          step_r <= STEP_W'(step_r + 1'b1);
          if (step_r == LAST_SQRT) begin
            state_r <= ST_ACC;
          end
        end
        ST_ACC: begin
          total_r <= total_nxt;
          dvd_r   <= total_nxt;
          drem_r  <= '0;
          slot_r  <= (slot_r == LAST_SLOT) ? '0 : SLOT_W'(slot_r + 1'b1);
          fill_r  <= fill_nxt;
          step_r  <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          dvd_r  <= {dvd_r[TOT_W-2:0], dv_ge};
          drem_r <= drem_nxt;
          step_r <= STEP_W'(step_r + 1'b1);
          if (step_r == LAST_DIV) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!r_full) begin
            open_r  <= open_nxt;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/vector_deviation_hysteresis_detector.sv -----
// Channel   Handshake          Accept when         Payload
// input     in_push / in_full  in_push && !in_full in_flux_x, in_flux_y, in_flux_z
// result    out_pop / out_empty out_pop && !out_empty out_avg_deviation, out_door_open,
//                                                  out_closing_event
// config    cfg_we             cfg_we              cfg_index, cfg_wdata
//
// Front end takes one beat at a time: accept, 4 steps through one shared
// squarer (3 squares plus the last add), then the push into the middle queue.
// Back end also works one beat at a time: 17 square root steps, the window
// update, one divide step per bit of the running total, then the result push.
// A two-entry queue sits between the ends and another before the result port,
// so either side may stall without holding up the other.
// rst_n is synchronous; window contents need no clearing pass.
module vector_deviation_hysteresis_detector #(
  parameter int WINDOW_LENGTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_push,
  output logic                                   in_full,
  input  logic signed [vdhd_pkg::FLUX_W-1:0]     in_flux_x,
  input  logic signed [vdhd_pkg::FLUX_W-1:0]     in_flux_y,
  input  logic signed [vdhd_pkg::FLUX_W-1:0]     in_flux_z,
  output logic                                   out_empty,
  input  logic                                   out_pop,
  output logic [vdhd_pkg::LEN_W-1:0]             out_avg_deviation,
  output logic                                   out_door_open,
  output logic                                   out_closing_event,
  input  logic                                   cfg_we,
  input  logic [vdhd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [vdhd_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
  import vdhd_pkg::*;

  vec_t             ref_r;
  logic [THR_W-1:0] open_thr_r;
  logic [THR_W-1:0] close_thr_r;
  vec_t             flux;
  logic             mid_push;
  logic [SUM_W-1:0] mid_wdata;
  logic             mid_full;
  logic             mid_pop;
  logic [SUM_W-1:0] mid_rdata;
  logic             mid_empty;
  logic             res_push;
  res_t             res_wdata;
  logic             res_full;
  res_t             res_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r       <= '0;
      open_thr_r  <= '1;
      close_thr_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REF_X:     ref_r.x     <= cfg_wdata[FLUX_W-1:0];
        REG_REF_Y:     ref_r.y     <= cfg_wdata[FLUX_W-1:0];
        REG_REF_Z:     ref_r.z     <= cfg_wdata[FLUX_W-1:0];
        REG_OPEN_THR:  open_thr_r  <= cfg_wdata[THR_W-1:0];
        REG_CLOSE_THR: close_thr_r <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign flux = '{x: in_flux_x, y: in_flux_y, z: in_flux_z};

  vdhd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .flux    (flux),
    .ref_vec (ref_r),
    .q_push  (mid_push),
    .q_data  (mid_wdata),
    .q_full  (mid_full)
  );

  vdhd_fifo #(.WIDTH(SUM_W)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (mid_wdata),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  vdhd_back #(.WINDOW_LENGTH(WINDOW_LENGTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (mid_empty),
    .q_pop     (mid_pop),
    .q_data    (mid_rdata),
    .open_thr  (open_thr_r),
    .close_thr (close_thr_r),
    .r_push    (res_push),
    .r_data    (res_wdata),
    .r_full    (res_full)
  );

  vdhd_fifo #(.WIDTH($bits(res_t))) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_rdata),
    .empty (out_empty)
  );

  assign out_avg_deviation = res_rdata.avg;
  assign out_door_open     = res_rdata.door_open;
  assign out_closing_event = res_rdata.closing;

endmodule

// ----- rtl/vdhd_checker.sv -----
module vdhd_props (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_push,
  input logic                                in_full,
  input logic                                out_empty,
  input logic                                out_pop,
  input logic [vdhd_pkg::LEN_W-1:0]          out_avg_deviation,
  input logic                                out_door_open,
  input logic                                out_closing_event
);

  // both queues come out of reset drained and the front end idle
  a_reset_clean: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> out_empty && !in_full)
    else $error("queues not drained after reset");

  // a closing beat always leaves the detector armed
  a_close_arms: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_closing_event) |-> !out_door_open)
    else $error("closing beat reports door open");

  // front end stays busy after taking a beat, until its result is pushed
  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |=> in_full)
    else $error("front end took a second beat at once");

  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty && $stable(out_avg_deviation))
    else $error("waiting result changed");

endmodule

bind vector_deviation_hysteresis_detector vdhd_props u_vdhd_props (.*);
